// ===== sv/bitmask_first_fit_offset_core_defines.svh =====
`ifndef BITMASK_FIRST_FIT_OFFSET_CORE_DEFINES_SVH
`define BITMASK_FIRST_FIT_OFFSET_CORE_DEFINES_SVH

// Same-cycle check, sampled on clk, off while rst_n is low
`define BMFF_CHECK_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle check, sampled on clk, off while rst_n is low
`define BMFF_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/bmff_pkg.sv =====
package bmff_pkg;

  // Beat field widths
  localparam int KIND_W  = 2;
  localparam int SLOT_W  = 8;
  localparam int WORD_W  = 64;
  localparam int LA_W    = 15;
  localparam int LB_W    = 9;
  localparam int OFF_W   = 15;

  // Internal widths, sized for the largest supported word and store
  localparam int HINT_W  = 9;
  localparam int SHIFT_W = 6;
  localparam int IDX_W   = 13;
  localparam int POS_W   = 17;
  localparam int KPOS_W  = 11;
  localparam int K_W     = 7;

  localparam logic [HINT_W-1:0] HINT_MAX = 9'd511;

  typedef enum logic [KIND_W-1:0] {
    KIND_WR_A     = 2'd0,
    KIND_WR_B     = 2'd1,
    KIND_SEARCH   = 2'd2,
    KIND_CLR_HINT = 2'd3
  } kind_t;

  // Sequencer to probe datapath
  typedef struct packed {
    logic [SHIFT_W-1:0] shift;   // bit shift of the pattern
    logic               first;   // first pattern word of this shift
    logic               b_live;  // pattern word index within pattern length
    logic               a_live;  // occupancy word index within occupancy length
    logic               step;    // probe cycle, data on the store outputs is valid
  } probe_ctl_t;

endpackage

// ===== sv/bmff_store.sv =====
module bmff_store #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 64,
  parameter int IW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [IW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  localparam int            AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [IW-1:0] LIMIT = IW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port, addresses past the store are dropped
  always_ff @(posedge clk) begin
    if (we && (waddr < LIMIT)) begin
      mem[waddr[AW-1:0]] <= wdata;
    end
  end

  // Registered read, addresses past the store read as free (zero)
  always_ff @(posedge clk) begin
    rdata_r <= (raddr < LIMIT) ? mem[raddr[AW-1:0]] : '0;
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/bmff_probe.sv =====
module bmff_probe #(
  parameter int SLOT_BITS = 64
) (
  input  logic                 clk,
  input  bmff_pkg::probe_ctl_t ctl,
  input  logic [SLOT_BITS-1:0] a_word,
  input  logic [SLOT_BITS-1:0] b_word,
  output logic                 hit
);

  import bmff_pkg::*;

  logic [SLOT_BITS-1:0] b_prev_r;
  logic [SLOT_BITS-1:0] lo_part;
  logic [SLOT_BITS-1:0] carry_part;
  logic [SHIFT_W:0]     rsh;

  // Previous pattern word feeds the carry into the next occupancy word
  always_ff @(posedge clk) begin
    if (ctl.step) begin
      b_prev_r <= b_word;
    end
  end

  assign rsh        = (SHIFT_W+1)'(SLOT_BITS) - {1'b0, ctl.shift};
  assign lo_part    = ctl.b_live ? (b_word << ctl.shift) : '0;
  assign carry_part = ((ctl.shift != '0) && !ctl.first) ? (b_prev_r >> rsh) : '0;

  // Collision against the occupancy word
  assign hit = ctl.a_live && (|((lo_part | carry_part) & a_word));

endmodule

// ===== sv/bitmask_first_fit_offset_core.sv =====
// Channel | Direction | Handshake            | Beat fields
// in_     | input     | in_valid / in_stall  | kind, slot_index, word_value, a_length, b_length
// out_    | output    | out_valid / out_stall| offset, at_end, bad_pattern
//
// A search steps past every occupancy word that is full or was tried at every shift, and for
// each shift tried compares the pattern words up to b_length (fewer on an early collision);
// one occupancy and one pattern word are read a cycle.
// After reset the occupancy store is cleared word by word with in_stall high.
// A result waits in the output register; further beats are taken meanwhile, but a search
// that finishes while that register is still full holds until it drains.
`include "bitmask_first_fit_offset_core_defines.svh"

module bitmask_first_fit_offset_core #(
  parameter int SLOT_BITS = 64,
  parameter int A_SLOTS   = 256,
  parameter int B_SLOTS   = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [bmff_pkg::KIND_W-1:0]  in_kind,
  input  logic [bmff_pkg::SLOT_W-1:0]  in_slot_index,
  input  logic [bmff_pkg::WORD_W-1:0]  in_word_value,
  input  logic [bmff_pkg::LA_W-1:0]    in_a_length,
  input  logic [bmff_pkg::LB_W-1:0]    in_b_length,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [bmff_pkg::OFF_W-1:0]   out_offset,
  output logic                         out_at_end,
  output logic                         out_bad_pattern
);

  import bmff_pkg::*;

  localparam logic [POS_W-1:0]   STEP_POS   = POS_W'(SLOT_BITS);
  localparam logic [KPOS_W-1:0]  STEP_KPOS  = KPOS_W'(SLOT_BITS);
  localparam logic [SHIFT_W-1:0] SHIFT_LAST = SHIFT_W'(SLOT_BITS - 1);
  localparam logic [IDX_W-1:0]   CLR_LAST   = IDX_W'(A_SLOTS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK0,
    ST_SCAN,
    ST_PROBE,
    ST_RESULT
  } state_t;

  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    clr_idx_r, clr_idx_nxt;
  logic [HINT_W-1:0]   hint_r, hint_nxt;
  logic                first_r, first_nxt;
  logic [LA_W-1:0]     len_a_r, len_a_nxt;
  logic [LB_W-1:0]     len_b_r, len_b_nxt;
  logic [IDX_W-1:0]    i_r, i_nxt;
  logic [POS_W-1:0]    i_pos_r, i_pos_nxt;
  logic [IDX_W-1:0]    a_idx_r, a_idx_nxt;
  logic [POS_W-1:0]    a_pos_r, a_pos_nxt;
  logic [K_W-1:0]      k_r, k_nxt;
  logic [KPOS_W-1:0]   k_pos_r, k_pos_nxt;
  logic [SHIFT_W-1:0]  j_r, j_nxt;
  logic [OFF_W-1:0]    res_off_r, res_off_nxt;
  logic                res_end_r, res_end_nxt;
  logic                res_bad_r, res_bad_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OFF_W-1:0]    out_offset_r, out_offset_nxt;
  logic                out_at_end_r, out_at_end_nxt;
  logic                out_bad_r, out_bad_nxt;

  logic                 a_we, b_we;
  logic [IDX_W-1:0]     a_waddr;
  logic [SLOT_BITS-1:0] a_wdata;
  logic [SLOT_BITS-1:0] a_q, b_q;
  logic                 hit;
  probe_ctl_t           pctl;

  logic                 a_full, a_in, b_in, k_last, j_more;
  logic [HINT_W-1:0]    hint_sat;
  logic [POS_W-1:0]     start_pos, fit_off;

  // Word stores
  bmff_store #(
    .DEPTH (A_SLOTS),
    .WIDTH (SLOT_BITS),
    .IW    (IDX_W)
  ) u_a_store (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (a_wdata),
    .raddr (a_idx_nxt),
    .rdata (a_q)
  );

  bmff_store #(
    .DEPTH (B_SLOTS),
    .WIDTH (SLOT_BITS),
    .IW    (SLOT_W)
  ) u_b_store (
    .clk   (clk),
    .we    (b_we),
    .waddr (in_slot_index),
    .wdata (in_word_value[SLOT_BITS-1:0]),
    .raddr (SLOT_W'(k_nxt)),
    .rdata (b_q)
  );

  // Shift-and-collide datapath
  assign pctl.shift  = j_r;
  assign pctl.first  = (k_r == '0);
  assign pctl.b_live = b_in;
  assign pctl.a_live = a_in;
  assign pctl.step   = (state_r == ST_PROBE);

  bmff_probe #(
    .SLOT_BITS (SLOT_BITS)
  ) u_probe (
    .clk    (clk),
    .ctl    (pctl),
    .a_word (a_q),
    .b_word (b_q),
    .hit    (hit)
  );

  // Range tests by bit position, so no division by the word size
  assign a_full    = &a_q;
  assign a_in      = (a_pos_r <= POS_W'(len_a_r));
  assign b_in      = (k_pos_r <= KPOS_W'(len_b_r));
  assign k_last    = (j_r == '0) ? ((k_pos_r + STEP_KPOS) > KPOS_W'(len_b_r)) : !b_in;
  assign j_more    = (j_r < SHIFT_LAST) && (LA_W'(j_r) < len_a_r);
  assign hint_sat  = (i_r > IDX_W'(HINT_MAX)) ? HINT_MAX : i_r[HINT_W-1:0];
  assign start_pos = POS_W'(hint_r) * STEP_POS;
  assign fit_off   = i_pos_r + POS_W'(j_r);

  assign in_stall  = (state_r != ST_IDLE);

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    hint_nxt       = hint_r;
    first_nxt      = first_r;
    len_a_nxt      = len_a_r;
    len_b_nxt      = len_b_r;
    i_nxt          = i_r;
    i_pos_nxt      = i_pos_r;
    a_idx_nxt      = a_idx_r;
    a_pos_nxt      = a_pos_r;
    k_nxt          = k_r;
    k_pos_nxt      = k_pos_r;
    j_nxt          = j_r;
    res_off_nxt    = res_off_r;
    res_end_nxt    = res_end_r;
    res_bad_nxt    = res_bad_r;
    out_valid_nxt  = out_valid_r & out_stall;
    out_offset_nxt = out_offset_r;
    out_at_end_nxt = out_at_end_r;
    out_bad_nxt    = out_bad_r;
    a_we           = 1'b0;
    b_we           = 1'b0;
    a_waddr        = IDX_W'(in_slot_index);
    a_wdata        = in_word_value[SLOT_BITS-1:0];

    unique case (state_r)
      ST_CLEAR: begin
        a_we        = 1'b1;
        a_waddr     = clr_idx_r;
        a_wdata     = '0;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == CLR_LAST) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          unique case (kind_t'(in_kind))
            KIND_WR_A: begin
              a_we = 1'b1;
            end
            KIND_WR_B: begin
              b_we = 1'b1;
            end
            KIND_CLR_HINT: begin
              hint_nxt = '0;
            end
            KIND_SEARCH: begin
              len_a_nxt = in_a_length;
              len_b_nxt = in_b_length;
              i_nxt     = IDX_W'(hint_r);
              a_idx_nxt = IDX_W'(hint_r);
              i_pos_nxt = start_pos;
              a_pos_nxt = start_pos;
              k_nxt     = '0;
              first_nxt = 1'b1;
              state_nxt = ST_CHECK0;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      // Pattern word 0 and the hinted occupancy word are on the store outputs
      ST_CHECK0: begin
        if (!b_q[0]) begin
          res_off_nxt = '0;
          res_end_nxt = 1'b0;
          res_bad_nxt = 1'b1;
          state_nxt   = ST_RESULT;
        end else begin
          state_nxt   = ST_SCAN;
        end
      end

      // Skip full occupancy words; at the first other word update the hint, then probe or end the search
      ST_SCAN: begin
        if (a_in && a_full) begin
          i_nxt     = i_r + 1'b1;
          a_idx_nxt = i_r + 1'b1;
          i_pos_nxt = i_pos_r + STEP_POS;
          a_pos_nxt = i_pos_r + STEP_POS;
        end else begin
          if (first_r) begin
            hint_nxt  = hint_sat;
            first_nxt = 1'b0;
          end
          if (!a_in) begin
            res_off_nxt = len_a_r;
            res_end_nxt = 1'b1;
            res_bad_nxt = 1'b0;
            state_nxt   = ST_RESULT;
          end else begin
            j_nxt     = '0;
            k_nxt     = '0;
            k_pos_nxt = '0;
            state_nxt = ST_PROBE;
          end
        end
      end

      // One pattern word against one occupancy word per cycle
      ST_PROBE: begin
        if (hit) begin
          if (j_more) begin
            j_nxt     = j_r + 1'b1;
            k_nxt     = '0;
            k_pos_nxt = '0;
            a_idx_nxt = i_r;
            a_pos_nxt = i_pos_r;
          end else begin
            i_nxt     = i_r + 1'b1;
            a_idx_nxt = i_r + 1'b1;
            i_pos_nxt = i_pos_r + STEP_POS;
            a_pos_nxt = i_pos_r + STEP_POS;
            state_nxt = ST_SCAN;
          end
        end else if (k_last) begin
          res_off_nxt = fit_off[OFF_W-1:0];
          res_end_nxt = 1'b0;
          res_bad_nxt = 1'b0;
          state_nxt   = ST_RESULT;
        end else begin
          k_nxt     = k_r + 1'b1;
          k_pos_nxt = k_pos_r + STEP_KPOS;
          a_idx_nxt = a_idx_r + 1'b1;
          a_pos_nxt = a_pos_r + STEP_POS;
        end
      end

      // Hand the result to the output register once it is free
      ST_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_offset_nxt = res_off_r;
          out_at_end_nxt = res_end_r;
          out_bad_nxt    = res_bad_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      hint_r      <= '0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      hint_r      <= hint_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
    len_a_r      <= len_a_nxt;
    len_b_r      <= len_b_nxt;
    i_r          <= i_nxt;
    i_pos_r      <= i_pos_nxt;
    a_idx_r      <= a_idx_nxt;
    a_pos_r      <= a_pos_nxt;
    k_r          <= k_nxt;
    k_pos_r      <= k_pos_nxt;
    j_r          <= j_nxt;
    res_off_r    <= res_off_nxt;
    res_end_r    <= res_end_nxt;
    res_bad_r    <= res_bad_nxt;
    out_offset_r <= out_offset_nxt;
    out_at_end_r <= out_at_end_nxt;
    out_bad_r    <= out_bad_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_offset      = out_offset_r;
  assign out_at_end      = out_at_end_r;
  assign out_bad_pattern = out_bad_r;

  // Checks
  `BMFF_CHECK_NOW(a_probe_addr, state_r == ST_PROBE, a_idx_r == (i_r + IDX_W'(k_r)), "probe address out of step")
  `BMFF_CHECK_NOW(a_probe_hint, state_r == ST_PROBE, !first_r, "probe entered before hint update")
  `BMFF_CHECK_NOW(a_probe_range, state_r == ST_PROBE, i_pos_r <= POS_W'(len_a_r), "probe past occupancy length")
  `BMFF_CHECK_NEXT(a_check0_exit, state_r == ST_CHECK0, (state_r == ST_SCAN) || (state_r == ST_RESULT), "bad exit from pattern check")

endmodule
